@@ hw/rtl/afl_pkg.sv @@
// Package for the active fault list: shared constants, operation, status and state
// codes, and the per-cell control struct.
// No dependencies.
package afl_pkg;

  localparam int unsigned AFL_LIST_DEPTH   = 16;
  localparam int unsigned AFL_CODE_WIDTH   = 8;
  localparam int unsigned AFL_SOURCE_WIDTH = 8;

  // Port widths fixed by the interface.
  localparam int unsigned OP_W     = 3;
  localparam int unsigned CODE_W   = 8;
  localparam int unsigned SOURCE_W = 8;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned LINE_W   = 16;
  localparam int unsigned INDEX_W  = 8;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned COUNT_W  = 5;

  typedef enum logic [OP_W-1:0] {
    OP_SET       = 3'd0,
    OP_CLEAR     = 3'd1,
    OP_CLEAR_ALL = 3'd2,
    OP_READ      = 3'd3,
    OP_ENABLE    = 3'd4,
    OP_DISABLE   = 3'd5
  } afl_op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE      = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_FULL      = 3'd2,
    ST_DISABLED  = 3'd3,
    ST_NOT_FOUND = 3'd4
  } afl_status_e;

  typedef enum logic [1:0] {
    FSM_IDLE = 2'b01,
    FSM_EXEC = 2'b10
  } afl_state_e;

  // Commands broadcast to every cell of the chain.
  typedef struct packed {
    logic insert;     // take the entry of the lower neighbor
    logic remove;     // cells at or above the hit take the upper neighbor
    logic clear_all;  // drop every entry
  } afl_cell_ctrl_t;

endpackage

@@ hw/rtl/afl_cell.sv @@
// One slot of the fault list: holds an entry, compares it with the key and shifts
// toward either neighbor. Depends on afl_pkg.
module afl_cell #(
  parameter int unsigned CODE_WIDTH   = afl_pkg::AFL_CODE_WIDTH,
  parameter int unsigned SOURCE_WIDTH = afl_pkg::AFL_SOURCE_WIDTH
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  afl_pkg::afl_cell_ctrl_t      ctrl_i,
  input  logic [CODE_WIDTH-1:0]        key_code_i,
  input  logic [SOURCE_WIDTH-1:0]      key_source_i,
  input  logic                         hit_i,
  output logic                         hit_o,
  input  logic                         prev_valid_i,
  input  logic [CODE_WIDTH-1:0]        prev_code_i,
  input  logic [SOURCE_WIDTH-1:0]      prev_source_i,
  input  logic [afl_pkg::TIME_W-1:0]   prev_time_i,
  input  logic [afl_pkg::LINE_W-1:0]   prev_line_i,
  input  logic                         next_valid_i,
  input  logic [CODE_WIDTH-1:0]        next_code_i,
  input  logic [SOURCE_WIDTH-1:0]      next_source_i,
  input  logic [afl_pkg::TIME_W-1:0]   next_time_i,
  input  logic [afl_pkg::LINE_W-1:0]   next_line_i,
  output logic                         valid_o,
  output logic [CODE_WIDTH-1:0]        code_o,
  output logic [SOURCE_WIDTH-1:0]      source_o,
  output logic [afl_pkg::TIME_W-1:0]   time_o,
  output logic [afl_pkg::LINE_W-1:0]   line_o
);
  import afl_pkg::*;

  logic                    valid_q, valid_d;
  logic [CODE_WIDTH-1:0]   code_q, code_d;
  logic [SOURCE_WIDTH-1:0] source_q, source_d;
  logic [TIME_W-1:0]       time_q, time_d;
  logic [LINE_W-1:0]       line_q, line_d;
  logic                    match;

  assign match = valid_q && (code_q == key_code_i) && (source_q == key_source_i);
  // Keys are unique, so the running OR marks every slot at or above the hit.
  assign hit_o = hit_i | match;

  always_comb begin
    valid_d  = valid_q;
    code_d   = code_q;
    source_d = source_q;
    time_d   = time_q;
    line_d   = line_q;
    priority if (ctrl_i.clear_all) begin
      valid_d = 1'b0;
    end else if (ctrl_i.insert) begin
      valid_d  = prev_valid_i;
      code_d   = prev_code_i;
      source_d = prev_source_i;
      time_d   = prev_time_i;
      line_d   = prev_line_i;
    end else if (ctrl_i.remove && hit_o) begin
      valid_d  = next_valid_i;
      code_d   = next_code_i;
      source_d = next_source_i;
      time_d   = next_time_i;
      line_d   = next_line_i;
    end else begin
      // The slot keeps its entry.
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    code_q   <= code_d;
    source_q <= source_d;
    time_q   <= time_d;
    line_q   <= line_d;
  end

  assign valid_o  = valid_q;
  assign code_o   = code_q;
  assign source_o = source_q;
  assign time_o   = time_q;
  assign line_o   = line_q;

endmodule

@@ hw/rtl/active_fault_list_unit.sv @@
// Top level of the active fault list: command port, sequencer and the chain of
// list cells. Depends on afl_pkg and afl_cell.
//
//   channel  | handshake        | payload
//   ---------+------------------+-------------------------------------------------
//   command  | start, busy      | operation_i fault_code_i source_id_i time_stamp_i
//            |                  | line_tag_i read_index_i
//   result   | done_o (strobe)  | status_o entry_found_o entry_code_o entry_source_o
//            |                  | entry_time_o entry_line_o fault_count_o
//            |                  | none_active_o notify_upstream_o
//
// A command beat is taken when start is high and busy is low. Busy is then high
// for one cycle while the cells compare the key and shift; the result beat shows
// on the next cycle with done_o. A new command may be taken in the cycle the result
// is shown. The receiver cannot stall. Reset empties the list and enables
// detection; stored entries themselves are not cleared.
module active_fault_list_unit #(
  parameter int unsigned LIST_DEPTH   = afl_pkg::AFL_LIST_DEPTH,
  parameter int unsigned CODE_WIDTH   = afl_pkg::AFL_CODE_WIDTH,
  parameter int unsigned SOURCE_WIDTH = afl_pkg::AFL_SOURCE_WIDTH
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  logic [afl_pkg::OP_W-1:0]       operation_i,
  input  logic [afl_pkg::CODE_W-1:0]     fault_code_i,
  input  logic [afl_pkg::SOURCE_W-1:0]   source_id_i,
  input  logic [afl_pkg::TIME_W-1:0]     time_stamp_i,
  input  logic [afl_pkg::LINE_W-1:0]     line_tag_i,
  input  logic [afl_pkg::INDEX_W-1:0]    read_index_i,
  output logic                           done_o,
  output logic [afl_pkg::STATUS_W-1:0]   status_o,
  output logic                           entry_found_o,
  output logic [afl_pkg::CODE_W-1:0]     entry_code_o,
  output logic [afl_pkg::SOURCE_W-1:0]   entry_source_o,
  output logic [afl_pkg::TIME_W-1:0]     entry_time_o,
  output logic [afl_pkg::LINE_W-1:0]     entry_line_o,
  output logic [afl_pkg::COUNT_W-1:0]    fault_count_o,
  output logic                           none_active_o,
  output logic                           notify_upstream_o
);
  import afl_pkg::*;

  localparam int unsigned CNT_W = $clog2(LIST_DEPTH + 1);

  afl_state_e              state_q, state_d;
  logic                    accept;

  // Command captured at the accept edge.
  afl_op_e                 op_q;
  logic [CODE_WIDTH-1:0]   key_code_q;
  logic [SOURCE_WIDTH-1:0] key_source_q;
  logic [TIME_W-1:0]       time_q;
  logic [LINE_W-1:0]       line_q;
  logic [INDEX_W-1:0]      ridx_q;
  logic [CODE_WIDTH+CODE_W-1:0]     code_ext;
  logic [SOURCE_WIDTH+SOURCE_W-1:0] source_ext;

  logic [CNT_W-1:0]        count_q, count_d;
  logic                    en_q, en_d;

  afl_cell_ctrl_t          cell_ctrl;
  logic [LIST_DEPTH:0]     hit_w;
  logic [LIST_DEPTH-1:0]   cell_valid;
  logic [CODE_WIDTH-1:0]   cell_code   [LIST_DEPTH];
  logic [SOURCE_WIDTH-1:0] cell_source [LIST_DEPTH];
  logic [TIME_W-1:0]       cell_time   [LIST_DEPTH];
  logic [LINE_W-1:0]       cell_line   [LIST_DEPTH];
  logic                    any_hit;

  // Read selection.
  logic                    sel_valid;
  logic [CODE_WIDTH-1:0]   sel_code;
  logic [SOURCE_WIDTH-1:0] sel_source;
  logic [TIME_W-1:0]       sel_time;
  logic [LINE_W-1:0]       sel_line;
  logic                    in_range;

  // Result beat.
  logic                    done_q;
  afl_status_e             status_q, status_d;
  logic                    found_q, found_d;
  logic [CODE_WIDTH-1:0]   rd_code_q, rd_code_d;
  logic [SOURCE_WIDTH-1:0] rd_source_q, rd_source_d;
  logic [TIME_W-1:0]       rd_time_q, rd_time_d;
  logic [LINE_W-1:0]       rd_line_q, rd_line_d;
  logic [CNT_W-1:0]        res_count_q;
  logic                    none_q, none_d;
  logic                    notify_q, notify_d;
  logic [CNT_W+COUNT_W-1:0]         cnt_ext;
  logic [CODE_WIDTH+CODE_W-1:0]     out_code_ext;
  logic [SOURCE_WIDTH+SOURCE_W-1:0] out_source_ext;

  assign busy   = (state_q == FSM_EXEC);
  assign accept = start && !busy;

  // Keys are kept in the configured widths, taken from the low port bits.
  assign code_ext   = {{CODE_WIDTH{1'b0}}, fault_code_i};
  assign source_ext = {{SOURCE_WIDTH{1'b0}}, source_id_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FSM_IDLE;
      count_q <= '0;
      en_q    <= 1'b1;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      en_q    <= en_d;
      done_q  <= busy;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q         <= afl_op_e'(operation_i);
      key_code_q   <= code_ext[CODE_WIDTH-1:0];
      key_source_q <= source_ext[SOURCE_WIDTH-1:0];
      time_q       <= time_stamp_i;
      line_q       <= line_tag_i;
      ridx_q       <= read_index_i;
    end
    if (busy) begin
      status_q    <= status_d;
      found_q     <= found_d;
      rd_code_q   <= rd_code_d;
      rd_source_q <= rd_source_d;
      rd_time_q   <= rd_time_d;
      rd_line_q   <= rd_line_d;
      res_count_q <= count_d;
      none_q      <= none_d;
      notify_q    <= notify_d;
    end
  end

  // Cell chain: slot 0 is the newest entry; an insert feeds the command in at slot 0,
  // a removal pulls an empty slot in past the top.
  assign hit_w[0] = 1'b0;
  assign any_hit  = hit_w[LIST_DEPTH];

  for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
    logic                    prev_valid, next_valid;
    logic [CODE_WIDTH-1:0]   prev_code, next_code;
    logic [SOURCE_WIDTH-1:0] prev_source, next_source;
    logic [TIME_W-1:0]       prev_time, next_time;
    logic [LINE_W-1:0]       prev_line, next_line;

    if (i == 0) begin : g_head
      assign prev_valid  = 1'b1;
      assign prev_code   = key_code_q;
      assign prev_source = key_source_q;
      assign prev_time   = time_q;
      assign prev_line   = line_q;
    end else begin : g_body
      assign prev_valid  = cell_valid[i-1];
      assign prev_code   = cell_code[i-1];
      assign prev_source = cell_source[i-1];
      assign prev_time   = cell_time[i-1];
      assign prev_line   = cell_line[i-1];
    end

    if (i == LIST_DEPTH - 1) begin : g_tail
      assign next_valid  = 1'b0;
      assign next_code   = '0;
      assign next_source = '0;
      assign next_time   = '0;
      assign next_line   = '0;
    end else begin : g_inner
      assign next_valid  = cell_valid[i+1];
      assign next_code   = cell_code[i+1];
      assign next_source = cell_source[i+1];
      assign next_time   = cell_time[i+1];
      assign next_line   = cell_line[i+1];
    end

    afl_cell #(
      .CODE_WIDTH   (CODE_WIDTH),
      .SOURCE_WIDTH (SOURCE_WIDTH)
    ) u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctrl_i        (cell_ctrl),
      .key_code_i    (key_code_q),
      .key_source_i  (key_source_q),
      .hit_i         (hit_w[i]),
      .hit_o         (hit_w[i+1]),
      .prev_valid_i  (prev_valid),
      .prev_code_i   (prev_code),
      .prev_source_i (prev_source),
      .prev_time_i   (prev_time),
      .prev_line_i   (prev_line),
      .next_valid_i  (next_valid),
      .next_code_i   (next_code),
      .next_source_i (next_source),
      .next_time_i   (next_time),
      .next_line_i   (next_line),
      .valid_o       (cell_valid[i]),
      .code_o        (cell_code[i]),
      .source_o      (cell_source[i]),
      .time_o        (cell_time[i]),
      .line_o        (cell_line[i])
    );
  end

  // At most one slot matches the read position, so an OR of the gated slots selects it.
  always_comb begin
    sel_valid  = 1'b0;
    sel_code   = '0;
    sel_source = '0;
    sel_time   = '0;
    sel_line   = '0;
    for (int i = 0; i < LIST_DEPTH; i++) begin
      if (cell_valid[i] && (ridx_q == INDEX_W'(i))) begin
        sel_valid  = 1'b1;
        sel_code   = sel_code | cell_code[i];
        sel_source = sel_source | cell_source[i];
        sel_time   = sel_time | cell_time[i];
        sel_line   = sel_line | cell_line[i];
      end
    end
  end

  assign in_range = ({{CNT_W{1'b0}}, ridx_q} < {{INDEX_W{1'b0}}, count_q});

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    en_d        = en_q;
    cell_ctrl   = '0;
    status_d    = ST_DONE;
    found_d     = 1'b0;
    notify_d    = 1'b0;
    rd_code_d   = '0;
    rd_source_d = '0;
    rd_time_d   = '0;
    rd_line_d   = '0;

    unique case (state_q)
      FSM_IDLE: begin
        if (accept) begin
          state_d = FSM_EXEC;
        end
      end
      FSM_EXEC: begin
        state_d = FSM_IDLE;
        unique case (op_q)
          OP_SET: begin
            priority if (!en_q) begin
              status_d = ST_DISABLED;
            end else if (any_hit) begin
              status_d = ST_DUPLICATE;
            end else if (count_q == CNT_W'(LIST_DEPTH)) begin
              status_d = ST_FULL;
            end else begin
              cell_ctrl.insert = 1'b1;
              count_d          = count_q + CNT_W'(1);
              notify_d         = 1'b1;
            end
          end
          OP_CLEAR: begin
            if (any_hit) begin
              cell_ctrl.remove = 1'b1;
              count_d          = count_q - CNT_W'(1);
              notify_d         = 1'b1;
            end else begin
              status_d = ST_NOT_FOUND;
            end
          end
          OP_CLEAR_ALL: begin
            cell_ctrl.clear_all = 1'b1;
            count_d             = '0;
            notify_d            = (count_q != '0);
          end
          OP_READ: begin
            if (in_range && sel_valid) begin
              found_d     = 1'b1;
              rd_code_d   = sel_code;
              rd_source_d = sel_source;
              rd_time_d   = sel_time;
              rd_line_d   = sel_line;
            end else begin
              status_d = ST_NOT_FOUND;
            end
          end
          OP_ENABLE: begin
            en_d = 1'b1;
          end
          OP_DISABLE: begin
            en_d                = 1'b0;
            cell_ctrl.clear_all = 1'b1;
            count_d             = '0;
            notify_d            = (count_q != '0);
          end
          default: begin
            // Unused operation codes leave everything as it is.
          end
        endcase
      end
      default: begin
        state_d = FSM_IDLE;
      end
    endcase
  end

  assign none_d = (count_d == '0) || !en_d;

  // Result fields are narrowed or widened to the fixed port widths.
  assign cnt_ext        = {{COUNT_W{1'b0}}, res_count_q};
  assign out_code_ext   = {{CODE_W{1'b0}}, rd_code_q};
  assign out_source_ext = {{SOURCE_W{1'b0}}, rd_source_q};

  assign done_o            = done_q;
  assign status_o          = status_q;
  assign entry_found_o     = found_q;
  assign entry_code_o      = out_code_ext[CODE_W-1:0];
  assign entry_source_o    = out_source_ext[SOURCE_W-1:0];
  assign entry_time_o      = rd_time_q;
  assign entry_line_o      = rd_line_q;
  assign fault_count_o     = (cnt_ext > (CNT_W + COUNT_W)'(31)) ? COUNT_W'(31)
                                                                 : cnt_ext[COUNT_W-1:0];
  assign none_active_o     = none_q;
  assign notify_upstream_o = notify_q;

  // The list stays packed: the count always equals the number of occupied slots.
  a_count_matches_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(cell_valid) == int'(count_q))
    else $error("fault count differs from occupied slots");

  // Occupied slots form a prefix starting at the head.
  a_list_packed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((cell_valid & (cell_valid + LIST_DEPTH'(1))) == '0))
    else $error("fault list has a gap");

  // Busy always drops again in the cycle after it is raised.
  a_exec_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |=> !busy)
    else $error("execution lasted more than one cycle");

  // A result beat appears in the cycle after execution.
  a_done_after_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |=> done_o)
    else $error("result beat missing after execution");

  // Detection disabled implies an empty list.
  a_disabled_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en_q |-> (count_q == '0))
    else $error("faults held while detection is disabled");

endmodule
